// ===== rtl/core/ppr_pkg.sv =====
// Shared types and constants for the packet preroll ring.
// Used by the top level and the staging buffer; depends on nothing.
`timescale 1ns / 1ps

package ppr_pkg;

    // Byte counts and packet lengths: 0..65 with the default 64-byte maximum, where 65 flags an overlong packet.
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int GEN_W  = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic [2:0] OP_STORE   = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_START   = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_DISCARD = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic [GEN_W-1:0]  generation_tag;
        logic [LEN_W-1:0]  room;
    } in_t;

    typedef struct packed {
        logic                 ok;
        logic [BYTE_W-1:0]    data_out;
        logic                 last_out;
        logic [LEN_W-1:0]     packet_length;
        logic [CNT_OUT_W-1:0] held_packets;
        logic [GEN_W-1:0]     generation;
        logic [GEN_W-1:0]     overwritten_count;
        logic [CNT_OUT_W-1:0] peak_packets;
    } out_t;

    // Requests from the sequencer to the staging buffer.
    typedef struct packed {
        logic              append;
        logic              clear;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  rd_idx;
    } stg_ctrl_t;

endpackage

// ===== rtl/core/packet_preroll_ring_unit.sv =====
// Top level of the packet preroll ring: sequencer, status counters and slot memories.
// Depends on ppr_pkg, ppr_ram and ppr_staging.
`timescale 1ns / 1ps

// A command word is taken when start is high and busy is low. Stores that do
// not end a packet, and all control commands, give one status word on the
// next cycle. A last byte that commits a packet of L bytes keeps busy high
// while the packet is copied from the staging memory into its slot, one byte
// a cycle over the single slot memory port. A successful pop of L bytes keeps
// busy high while the slot length is read and then one byte word is given per
// cycle on consecutive cycles. A failed pop gives one word: in the cycle after
// it is taken when disabled or empty, else once its length is read. Every
// result word is shown for exactly one cycle with result_strobe and cannot be
// held off. The enabled register is written with cfg_we while the block is idle.
module packet_preroll_ring_unit #(
    parameter int SLOTS            = 16,
    parameter int MAX_PACKET_BYTES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ppr_pkg::in_t  cmd,
    output logic          result_strobe,
    output ppr_pkg::out_t result,
    input  logic          cfg_we,
    input  logic          cfg_data
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int BIDX_W  = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int LEN_W   = ppr_pkg::LEN_W;
    localparam int GEN_W   = ppr_pkg::GEN_W;
    localparam int OUT_W   = ppr_pkg::CNT_OUT_W;

    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W:0]    SLOTS_SUM = (CNT_W + 1)'(SLOTS);

    localparam logic [1:0] S_IDLE       = 2'd0;
    localparam logic [1:0] S_POP_LEN    = 2'd1;
    localparam logic [1:0] S_POP_STREAM = 2'd2;
    localparam logic [1:0] S_COPY       = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic [GEN_W-1:0]  ovw_reg, ovw_next;
    logic              rec_reg, rec_next;
    logic              en_reg, en_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  room_reg, room_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              strobe_reg, strobe_next;
    ppr_pkg::out_t     out_reg, out_next;

    ppr_pkg::stg_ctrl_t       stg_ctrl;
    logic [LEN_W-1:0]         stg_len;
    logic [ppr_pkg::BYTE_W-1:0] stg_rdata;

    logic                        len_we;
    logic [LEN_W-1:0]            len_rdata;
    logic                        byte_we;
    logic [SLOT_W+BIDX_W-1:0]    byte_waddr;
    logic [SLOT_W+BIDX_W-1:0]    byte_raddr;
    logic [ppr_pkg::BYTE_W-1:0]  byte_rdata;

    logic [LEN_W-1:0]  len_app;
    logic [LEN_W-1:0]  idx_inc;
    logic [LEN_W-1:0]  idx_dec;
    logic [CNT_W:0]    tail_sum;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] head_inc;
    logic [CNT_W-1:0]  held_inc;
    logic              commit_ok;
    logic              res_ok;
    logic [ppr_pkg::BYTE_W-1:0] res_data;
    logic              res_last;
    logic [LEN_W-1:0]  res_len;

    // Length of the staged packet once the current store byte is counted.
    assign len_app  = (stg_len <= MAX_LEN) ? (stg_len + 1'b1) : stg_len;
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : (head_reg + 1'b1);
    assign held_inc = held_reg + 1'b1;
    assign tail_sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, head_reg} + {1'b0, held_reg};
    assign tail_slot = (tail_sum >= SLOTS_SUM) ? SLOT_W'(tail_sum - SLOTS_SUM)
                                               : SLOT_W'(tail_sum);
    assign commit_ok = en_reg && rec_reg && (cmd.generation_tag == gen_reg)
                       && (len_app != '0) && (len_app <= MAX_LEN);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        held_next   = held_reg;
        peak_next   = peak_reg;
        gen_next    = gen_reg;
        ovw_next    = ovw_reg;
        rec_next    = rec_reg;
        en_next     = en_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        room_next   = room_reg;
        slot_next   = slot_reg;
        strobe_next = 1'b0;
        res_ok      = 1'b0;
        res_data    = '0;
        res_last    = 1'b1;
        res_len     = '0;

        stg_ctrl        = '0;
        stg_ctrl.data   = cmd.data_byte;
        stg_ctrl.rd_idx = idx_reg;

        len_we     = 1'b0;
        byte_we    = 1'b0;
        byte_waddr = {slot_reg, idx_dec[BIDX_W-1:0]};
        byte_raddr = {head_reg, {BIDX_W{1'b0}}};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    case (cmd.op)
                        ppr_pkg::OP_STORE:
                        begin
                            stg_ctrl.append = 1'b1;
                            res_ok          = 1'b1;
                            if (cmd.last_byte)
                            begin
                                stg_ctrl.clear = 1'b1;
                                res_ok         = commit_ok;
                                if (commit_ok)
                                begin
                                    len_we    = 1'b1;
                                    len_next  = len_app;
                                    idx_next  = '0;
                                    state_next = S_COPY;
                                    if (held_reg >= SLOTS_CNT)
                                    begin
                                        slot_next = head_reg;
                                        head_next = head_inc;
                                        ovw_next  = ovw_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        slot_next = tail_slot;
                                        held_next = held_inc;
                                        if (held_inc > peak_reg)
                                        begin
                                            peak_next = held_inc;
                                        end
                                    end
                                end
                            end
                        end
                        ppr_pkg::OP_POP:
                        begin
                            // The length memory is always addressed by the head,
                            // so its word is ready in the next state.
                            if (en_reg && (held_reg != '0))
                            begin
                                strobe_next = 1'b0;
                                room_next   = cmd.room;
                                state_next  = S_POP_LEN;
                            end
                        end
                        ppr_pkg::OP_START:
                        begin
                            if (en_reg)
                            begin
                                res_ok = 1'b1;
                                if (!rec_reg)
                                begin
                                    gen_next  = gen_reg + 1'b1;
                                    head_next = '0;
                                    held_next = '0;
                                    rec_next  = 1'b1;
                                end
                            end
                        end
                        ppr_pkg::OP_STOP:
                        begin
                            res_ok = 1'b1;
                            if (rec_reg)
                            begin
                                gen_next = gen_reg + 1'b1;
                                rec_next = 1'b0;
                            end
                        end
                        ppr_pkg::OP_DISCARD:
                        begin
                            res_ok    = 1'b1;
                            head_next = '0;
                            held_next = '0;
                            gen_next  = gen_reg + 1'b1;
                        end
                        default:
                        begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
                if (cfg_we)
                begin
                    en_next   = cfg_data;
                    head_next = '0;
                    held_next = '0;
                    rec_next  = 1'b0;
                    gen_next  = gen_reg + 1'b1;
                end
            end
            S_POP_LEN:
            begin
                if ((len_rdata == '0) || (len_rdata > MAX_LEN) || (len_rdata > room_reg))
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    slot_next  = head_reg;
                    head_next  = head_inc;
                    held_next  = held_reg - 1'b1;
                    len_next   = len_rdata;
                    idx_next   = '0;
                    state_next = S_POP_STREAM;
                end
            end
            S_POP_STREAM:
            begin
                // The byte for idx_reg was read in the previous cycle; fetch the next one.
                byte_raddr  = {slot_reg, idx_inc[BIDX_W-1:0]};
                strobe_next = 1'b1;
                res_ok      = 1'b1;
                res_data    = byte_rdata;
                res_len     = len_reg;
                res_last    = (idx_inc == len_reg);
                idx_next    = idx_inc;
                if (idx_inc == len_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                // Staging read at idx_reg; the byte read in the previous cycle is
                // written to the slot at idx_reg - 1.
                byte_we  = (idx_reg != '0);
                idx_next = idx_inc;
                if (idx_reg == len_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_next                   = '0;
        out_next.ok                = res_ok;
        out_next.data_out          = res_data;
        out_next.last_out          = res_last;
        out_next.packet_length     = res_len;
        out_next.held_packets      = OUT_W'(held_next);
        out_next.generation        = gen_next;
        out_next.overwritten_count = ovw_next;
        out_next.peak_packets      = OUT_W'(peak_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            held_reg   <= '0;
            peak_reg   <= '0;
            gen_reg    <= '0;
            ovw_reg    <= '0;
            rec_reg    <= 1'b0;
            en_reg     <= 1'b0;
            idx_reg    <= '0;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            held_reg   <= held_next;
            peak_reg   <= peak_next;
            gen_reg    <= gen_next;
            ovw_reg    <= ovw_next;
            rec_reg    <= rec_next;
            en_reg     <= en_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        room_reg <= room_next;
        slot_reg <= slot_next;
        out_reg  <= out_next;
    end

    ppr_staging #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_staging (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (stg_ctrl),
        .len     (stg_len),
        .rd_data (stg_rdata)
    );

    // Slot lengths; written at commit, read at the head for a pop.
    ppr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (slot_next),
        .wdata (len_app),
        .raddr (head_reg),
        .rdata (len_rdata)
    );

    // Slot bytes; each slot takes a power-of-two stride of byte addresses.
    ppr_ram #(
        .WIDTH (ppr_pkg::BYTE_W),
        .DEPTH (SLOTS << BIDX_W)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (stg_rdata),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = out_reg;

`ifndef SYNTH
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= SLOTS_CNT)
        else $error("held packet count exceeds the ring size");

    a_peak_covers_held: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= held_reg)
        else $error("high-water mark below the held packet count");

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result word without a command or a running operation");

    a_copy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) && $past(state_reg == S_COPY) |-> !result_strobe)
        else $error("result word during a slot copy");

    a_stream_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_STREAM) |-> (idx_reg < len_reg))
        else $error("pop stream index ran past the packet length");
`endif

endmodule

// ===== rtl/core/ppr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ppr_staging.sv =====
// Staging buffer that collects the bytes of the packet being stored.
// Depends on ppr_pkg and ppr_ram.
`timescale 1ns / 1ps

module ppr_staging #(
    parameter int MAX_PACKET_BYTES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ppr_pkg::stg_ctrl_t        ctrl,
    output logic [ppr_pkg::LEN_W-1:0] len,
    output logic [ppr_pkg::BYTE_W-1:0] rd_data
);

    localparam int SDEPTH = (MAX_PACKET_BYTES < 2) ? 2 : MAX_PACKET_BYTES;
    localparam int SAW    = $clog2(SDEPTH);
    localparam logic [ppr_pkg::LEN_W-1:0] MAX_LEN = ppr_pkg::LEN_W'(MAX_PACKET_BYTES);

    logic [ppr_pkg::LEN_W-1:0] len_reg;
    logic [ppr_pkg::LEN_W-1:0] len_next;
    logic                      wr_en;

    // Bytes past the maximum are dropped; the count stops one above it
    // so that the packet is known to be too long.
    assign wr_en = ctrl.append && (len_reg < MAX_LEN);

    always_comb
    begin
        len_next = len_reg;
        if (ctrl.clear)
        begin
            len_next = '0;
        end
        else if (ctrl.append && (len_reg <= MAX_LEN))
        begin
            len_next = len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    ppr_ram #(
        .WIDTH (ppr_pkg::BYTE_W),
        .DEPTH (SDEPTH)
    ) u_stage_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (len_reg[SAW-1:0]),
        .wdata (ctrl.data),
        .raddr (ctrl.rd_idx[SAW-1:0]),
        .rdata (rd_data)
    );

    assign len = len_reg;

endmodule
